### rtl/core/rrmt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults for the row run mark table.
// No dependencies; used by rrmt_core and row_run_mark_table.
package rrmt_pkg;

   localparam int DEF_LAST_ROW = 32767;
   localparam int DEF_MAX_RUNS = 64;

   localparam int ROW_W  = 15;   // row fields on the ports
   localparam int WORK_W = 17;   // signed/extended row arithmetic

   typedef enum logic [2:0] {
      OP_SET    = 3'd0,
      OP_GET    = 3'd1,
      OP_ALL    = 3'd2,
      OP_NEXT   = 3'd3,
      OP_END    = 3'd4,
      OP_ONE    = 3'd5,
      OP_ISTART = 3'd6,
      OP_INEXT  = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_FIND, S_FCMP, S_CUR, S_PREV,
      S_RB_RD, S_RB_DAT, S_RB_FLUSH,
      S_ONE0, S_ONE1, S_ONE2,
      S_IT_RD, S_IT_DAT, S_IT_PRV, S_EMIT
   } state_type;

   typedef struct packed {
      op_type           op;
      logic [ROW_W-1:0] row_a;
      logic [ROW_W-1:0] row_b;
      logic             mark_value;
      logic             direction_up;
   } req_item_type;

   typedef struct packed {
      logic              flag;
      logic [WORK_W-1:0] row_first;
      logic [ROW_W-1:0]  row_second;
      logic              any_marked;
      status_type        status;
   } rsp_item_type;

endpackage

### rtl/core/rrmt_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rrmt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/rrmt_core.sv
`timescale 1ns / 1ps
// Sequencer and shared compare/add datapath of the row run mark table.
// Depends on rrmt_pkg; drives the run list RAM (two banks, ping-pong on rebuild).
module rrmt_core #(
   parameter int LAST_ROW = rrmt_pkg::DEF_LAST_ROW,
   parameter int MAX_RUNS = rrmt_pkg::DEF_MAX_RUNS,
   localparam int IW = $clog2(MAX_RUNS),
   localparam int EW = $clog2(LAST_ROW + 2),
   localparam int AW = IW + 1,
   localparam int DW = EW + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   output logic                  item_ready,
   input  rrmt_pkg::req_item_type item,
   output logic                  res_valid,
   input  logic                  res_room,
   output rrmt_pkg::rsp_item_type res,
   output logic                  ram_we,
   output logic [AW-1:0]         ram_waddr,
   output logic [DW-1:0]         ram_wdata,
   output logic [AW-1:0]         ram_raddr,
   input  logic [DW-1:0]         ram_rdata
);

   localparam int CW = $clog2(MAX_RUNS + 2);
   localparam int W  = rrmt_pkg::WORK_W;
   localparam logic [W-1:0]  LAST_X = W'(LAST_ROW);
   localparam logic [CW-1:0] MAX_C  = CW'(MAX_RUNS);
   localparam logic [CW-1:0] CNT1   = CW'(1);

   rrmt_pkg::state_type state_ff, state_in;
   rrmt_pkg::op_type    op_ff, op_in;
   rrmt_pkg::rsp_item_type res_ff, res_in;
   logic [W-1:0]  a_ff, a_in, b_ff, b_in, tgt_ff, tgt_in;
   logic          m_ff, m_in, up_ff, up_in;
   logic [CW-1:0] cnt_ff, cnt_in, iter_ff, iter_in;
   logic          bank_ff, bank_in, head_ff, head_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, keep_ff, keep_in, idx_ff, idx_in;
   logic          keep_mark_ff, keep_mark_in, phase_ff, phase_in, pass_ff, pass_in;
   logic [W-1:0]  cur_end_ff, cur_end_in, prv_end_ff, prv_end_in;
   logic          cur_mark_ff, cur_mark_in;
   logic [CW-1:0] ncnt_ff, ncnt_in;
   logic          pend_v_ff, pend_v_in, pend_mark_ff, pend_mark_in, nhead_ff, nhead_in;
   logic [W-1:0]  pend_end_ff, pend_end_in;

   logic [CW:0]   mid_sum;
   logic [CW-1:0] mid;
   logic [W-1:0]  rd_end, a_x, b_x, start_x;
   logic          rd_mark, a_ok, b_ok;
   logic          em_v, em_mark;
   logic [W-1:0]  em_end;
   logic [CW-1:0] rd_idx;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid     = mid_sum[CW:1];
   assign rd_end  = W'(ram_rdata[EW-1:0]);
   assign rd_mark = ram_rdata[EW];
   assign a_x     = W'(item.row_a);
   assign b_x     = W'(item.row_b);
   assign a_ok    = a_x <= LAST_X;
   assign b_ok    = b_x <= LAST_X;
   assign start_x = (idx_ff == '0) ? '0 : prv_end_ff + W'(1);
   assign ram_raddr = {bank_ff, rd_idx[IW-1:0]};
   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrmt_pkg::S_INIT;
         cnt_ff   <= CNT1;
         iter_ff  <= '0;
         bank_ff  <= 1'b0;
         head_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         iter_ff  <= iter_in;
         bank_ff  <= bank_in;
         head_ff  <= head_in;
      end
      op_ff <= op_in;  res_ff <= res_in;
      a_ff <= a_in;  b_ff <= b_in;  tgt_ff <= tgt_in;  m_ff <= m_in;  up_ff <= up_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;  keep_ff <= keep_in;  idx_ff <= idx_in;
      keep_mark_ff <= keep_mark_in;  phase_ff <= phase_in;  pass_ff <= pass_in;
      cur_end_ff <= cur_end_in;  prv_end_ff <= prv_end_in;  cur_mark_ff <= cur_mark_in;
      ncnt_ff <= ncnt_in;  pend_v_ff <= pend_v_in;  pend_mark_ff <= pend_mark_in;
      nhead_ff <= nhead_in;  pend_end_ff <= pend_end_in;
   end

   always_comb begin
      state_in = state_ff;  op_in = op_ff;  res_in = res_ff;
      a_in = a_ff;  b_in = b_ff;  tgt_in = tgt_ff;  m_in = m_ff;  up_in = up_ff;
      cnt_in = cnt_ff;  iter_in = iter_ff;  bank_in = bank_ff;  head_in = head_ff;
      lo_in = lo_ff;  hi_in = hi_ff;  keep_in = keep_ff;  idx_in = idx_ff;
      keep_mark_in = keep_mark_ff;  phase_in = phase_ff;  pass_in = pass_ff;
      cur_end_in = cur_end_ff;  prv_end_in = prv_end_ff;  cur_mark_in = cur_mark_ff;
      ncnt_in = ncnt_ff;  pend_v_in = pend_v_ff;  pend_mark_in = pend_mark_ff;
      nhead_in = nhead_ff;  pend_end_in = pend_end_ff;
      item_ready = 1'b0;
      res_valid  = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = {~bank_ff, pend_idx(ncnt_ff)};
      ram_wdata  = {pend_mark_ff, pend_end_ff[EW-1:0]};
      rd_idx     = idx_ff;
      em_v = 1'b0;  em_end = '0;  em_mark = 1'b0;

      unique case (state_ff)
         rrmt_pkg::S_INIT: begin
            // Seed entry 0 of bank 0: one unmarked run to the last row.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {1'b0, LAST_X[EW-1:0]};
            state_in  = rrmt_pkg::S_IDLE;
         end
         rrmt_pkg::S_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               op_in = item.op;  a_in = a_x;  b_in = b_x;
               m_in = item.mark_value;  up_in = item.direction_up;
               res_in = '0;
               tgt_in = a_x;  lo_in = '0;  hi_in = cnt_ff - CNT1;  phase_in = 1'b0;
               unique case (item.op)
                  rrmt_pkg::OP_SET: begin
                     if (!a_ok || !b_ok || a_x > b_x) begin
                        res_in.status = rrmt_pkg::ST_RANGE;
                        state_in = rrmt_pkg::S_EMIT;
                     end else begin
                        idx_in = '0;  pass_in = 1'b0;  ncnt_in = '0;  pend_v_in = 1'b0;
                        state_in = rrmt_pkg::S_RB_RD;
                     end
                  end
                  rrmt_pkg::OP_GET, rrmt_pkg::OP_END, rrmt_pkg::OP_NEXT: begin
                     if (!a_ok) begin
                        res_in.status = rrmt_pkg::ST_RANGE;
                        if (item.op == rrmt_pkg::OP_NEXT) res_in.row_first = a_x;
                        state_in = rrmt_pkg::S_EMIT;
                     end else begin
                        state_in = rrmt_pkg::S_FIND;
                     end
                  end
                  rrmt_pkg::OP_ALL: begin
                     if (!a_ok || !b_ok) begin
                        res_in.status = rrmt_pkg::ST_RANGE;
                        state_in = rrmt_pkg::S_EMIT;
                     end else begin
                        state_in = rrmt_pkg::S_FIND;
                     end
                  end
                  rrmt_pkg::OP_ONE:    state_in = rrmt_pkg::S_ONE0;
                  rrmt_pkg::OP_ISTART: begin
                     iter_in  = '0;
                     state_in = rrmt_pkg::S_EMIT;
                  end
                  rrmt_pkg::OP_INEXT:  state_in = rrmt_pkg::S_IT_RD;
                  default:             state_in = rrmt_pkg::S_EMIT;
               endcase
            end
         end
         rrmt_pkg::S_FIND: begin
            // binary search: each probe reads in S_FIND and compares in S_FCMP
            if (lo_ff < hi_ff) begin
               rd_idx   = mid;
               state_in = rrmt_pkg::S_FCMP;
            end else begin
               rd_idx   = lo_ff;
               state_in = rrmt_pkg::S_CUR;
            end
         end
         rrmt_pkg::S_FCMP: begin
            if (rd_end < tgt_ff) lo_in = mid + CNT1;
            else                 hi_in = mid;
            state_in = rrmt_pkg::S_FIND;
         end
         rrmt_pkg::S_CUR: begin
            cur_end_in  = rd_end;
            cur_mark_in = rd_mark;
            rd_idx      = lo_ff - CNT1;
            state_in    = rrmt_pkg::S_PREV;
         end
         rrmt_pkg::S_PREV: begin
            state_in = rrmt_pkg::S_EMIT;
            unique case (op_ff)
               rrmt_pkg::OP_GET: res_in.flag = cur_mark_ff;
               rrmt_pkg::OP_ALL: begin
                  if (!phase_ff) begin
                     keep_in = lo_ff;  keep_mark_in = cur_mark_ff;  phase_in = 1'b1;
                     tgt_in = b_ff;  lo_in = '0;  hi_in = cnt_ff - CNT1;
                     state_in = rrmt_pkg::S_FIND;
                  end else begin
                     res_in.flag = keep_mark_ff && (keep_ff == lo_ff);
                  end
               end
               rrmt_pkg::OP_NEXT: begin
                  if (cur_mark_ff)     res_in.row_first = a_ff;
                  else if (!up_ff)     res_in.row_first = cur_end_ff + W'(1);
                  else if (lo_ff != '0) res_in.row_first = rd_end;
                  else                 res_in.row_first = '1;
               end
               rrmt_pkg::OP_END: begin
                  if (!up_ff)          res_in.row_first = cur_end_ff;
                  else if (lo_ff != '0) res_in.row_first = rd_end + W'(1);
                  else                 res_in.row_first = '0;
               end
               default: ;
            endcase
         end
         rrmt_pkg::S_RB_RD: begin
            if (idx_ff < cnt_ff) begin
               state_in = rrmt_pkg::S_RB_DAT;
            end else if (!pass_ff) begin
               em_v = 1'b1;  em_end = b_ff;  em_mark = m_ff;
               pass_in = 1'b1;  idx_in = '0;
            end else begin
               state_in = rrmt_pkg::S_RB_FLUSH;
            end
         end
         rrmt_pkg::S_RB_DAT: begin
            if (!pass_ff) begin
               if (start_x < a_ff) begin
                  em_v = 1'b1;  em_mark = rd_mark;
                  em_end = (rd_end > a_ff - W'(1)) ? a_ff - W'(1) : rd_end;
               end
               prv_end_in = rd_end;
            end else if (rd_end > b_ff) begin
               em_v = 1'b1;  em_end = rd_end;  em_mark = rd_mark;
            end
            idx_in   = idx_ff + CNT1;
            state_in = rrmt_pkg::S_RB_RD;
         end
         rrmt_pkg::S_RB_FLUSH: begin
            ram_we = ncnt_ff <= MAX_C;
            if (ncnt_ff > MAX_C) begin
               res_in.status = rrmt_pkg::ST_FULL;
            end else begin
               bank_in = ~bank_ff;  cnt_in = ncnt_ff;  head_in = nhead_ff;
            end
            state_in = rrmt_pkg::S_EMIT;
         end
         rrmt_pkg::S_ONE0: begin
            rd_idx   = '0;
            state_in = rrmt_pkg::S_ONE1;
         end
         rrmt_pkg::S_ONE1: begin
            cur_end_in  = rd_end;
            cur_mark_in = rd_mark;
            rd_idx      = CNT1;
            state_in    = rrmt_pkg::S_ONE2;
         end
         rrmt_pkg::S_ONE2: begin
            if (cnt_ff == CNT1) begin
               if (cur_mark_ff) begin
                  res_in.flag = 1'b1;
                  res_in.row_second = LAST_X[rrmt_pkg::ROW_W-1:0];
               end
            end else if (cnt_ff == CW'(2)) begin
               res_in.flag = 1'b1;
               if (cur_mark_ff) begin
                  res_in.row_second = cur_end_ff[rrmt_pkg::ROW_W-1:0];
               end else begin
                  res_in.row_first  = cur_end_ff + W'(1);
                  res_in.row_second = LAST_X[rrmt_pkg::ROW_W-1:0];
               end
            end else if (cnt_ff == CW'(3) && rd_mark) begin
               res_in.flag       = 1'b1;
               res_in.row_first  = cur_end_ff + W'(1);
               res_in.row_second = rd_end[rrmt_pkg::ROW_W-1:0];
            end
            state_in = rrmt_pkg::S_EMIT;
         end
         rrmt_pkg::S_IT_RD: begin
            rd_idx = iter_ff;
            state_in = (iter_ff < cnt_ff) ? rrmt_pkg::S_IT_DAT : rrmt_pkg::S_EMIT;
         end
         rrmt_pkg::S_IT_DAT: begin
            if (!rd_mark) begin
               iter_in  = iter_ff + CNT1;
               state_in = rrmt_pkg::S_IT_RD;
            end else begin
               cur_end_in = rd_end;
               rd_idx     = iter_ff - CNT1;
               state_in   = rrmt_pkg::S_IT_PRV;
            end
         end
         rrmt_pkg::S_IT_PRV: begin
            res_in.flag       = 1'b1;
            res_in.row_second = cur_end_ff[rrmt_pkg::ROW_W-1:0];
            res_in.row_first  = (iter_ff == '0) ? '0 : rd_end + W'(1);
            iter_in  = iter_ff + CNT1;
            state_in = rrmt_pkg::S_EMIT;
         end
         rrmt_pkg::S_EMIT: begin
            res_valid = res_room;
            if (res_room) state_in = rrmt_pkg::S_IDLE;
         end
         default: state_in = rrmt_pkg::S_IDLE;
      endcase

      // run merge: equal marks extend the pending run, else the pending run is written out
      if (em_v) begin
         if (pend_v_ff && pend_mark_ff == em_mark) begin
            pend_end_in = em_end;
         end else begin
            if (pend_v_ff) ram_we = ncnt_ff <= MAX_C;
            else           nhead_in = em_mark;
            if (ncnt_ff <= MAX_C) ncnt_in = ncnt_ff + CNT1;
            pend_v_in = 1'b1;  pend_end_in = em_end;  pend_mark_in = em_mark;
         end
      end
      // any_marked must reflect the list as it stands when the beat leaves
      if (state_in == rrmt_pkg::S_EMIT) begin
         res_in.any_marked = (cnt_in > CNT1) || head_in;
      end
   end

   function automatic logic [IW-1:0] pend_idx(input logic [CW-1:0] n);
      logic [CW-1:0] k;
      k = n - CNT1;
      return k[IW-1:0];
   endfunction

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 && cnt_ff <= MAX_C)
      else $error("run count out of range");
   a_find_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrmt_pkg::S_FIND |-> lo_ff <= hi_ff)
      else $error("search bounds crossed");
   a_res_from_emit: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> state_ff == rrmt_pkg::S_EMIT && !item_ready)
      else $error("result outside emit state");
   a_bank_swap: assert property (@(posedge clock) disable iff (reset)
      bank_ff != $past(bank_ff) |-> $past(state_ff) == rrmt_pkg::S_RB_FLUSH)
      else $error("bank swapped outside rebuild");
`endif

endmodule

### rtl/core/row_run_mark_table.sv
`timescale 1ns / 1ps
// Row run mark table: a mark bit per row 0..LAST_ROW kept as a run list in one
// two-bank RAM, served one operation at a time. Depends on rrmt_pkg, rrmt_core, rrmt_ram.
//
// After reset the block seeds the run list before it takes a beat.
// Each request then runs to completion before the next is taken; every RAM read goes
// through the registered read port. Point queries (get mark, all marked, next marked,
// mark end) binary-search the run list, all marked searches twice; one mark reads
// the first two runs; iter next skips unmarked runs from the iterator position until a
// marked run is found or none is left; set range rebuilds the list into the idle bank.
module row_run_mark_table #(
   parameter int LAST_ROW = rrmt_pkg::DEF_LAST_ROW,
   parameter int MAX_RUNS = rrmt_pkg::DEF_MAX_RUNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // row_a[14:0], row_b[29:15], mark_value[30], direction_up[31]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // flag[0], row_first[17:1], row_second[32:18],
                                    // any_marked[33], zero[39:34]
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IW = $clog2(MAX_RUNS);
   localparam int EW = $clog2(LAST_ROW + 2);
   localparam int AW = IW + 1;
   localparam int DW = EW + 1;

   rrmt_pkg::req_item_type item;
   rrmt_pkg::rsp_item_type res, rsp_ff, rsp_in;
   logic          res_valid, rsp_valid_ff, rsp_valid_in, res_room;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [DW-1:0] ram_wdata, ram_rdata;

   assign item.op           = rrmt_pkg::op_type'(req_tuser);
   assign item.row_a        = req_tdata[14:0];
   assign item.row_b        = req_tdata[29:15];
   assign item.mark_value   = req_tdata[30];
   assign item.direction_up = req_tdata[31];

   assign res_room = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.any_marked, rsp_ff.row_second,
                        rsp_ff.row_first, rsp_ff.flag};
   assign rsp_tuser  = rsp_ff.status;

   rrmt_core #(
      .LAST_ROW (LAST_ROW),
      .MAX_RUNS (MAX_RUNS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .res_valid  (res_valid),
      .res_room   (res_room),
      .res        (res),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   rrmt_ram #(
      .WIDTH (DW),
      .DEPTH (2 ** AW)
   ) u_runs (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

### sim/rrmt_checker.sv
`timescale 1ns / 1ps
// Watches the request and response streams of row_run_mark_table, predicts each
// response from its own copy of the run list, and compares. Depends on rrmt_pkg.
module rrmt_checker
   import rrmt_pkg::*;
#(
   parameter int LAST_ROW = DEF_LAST_ROW,
   parameter int MAX_RUNS = DEF_MAX_RUNS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          fail_count,
   output int          pending_count,
   output int          full_seen,
   output int          rsp_count
);

   logic [ROW_W-1:0] run_end [MAX_RUNS];
   logic             run_mark [MAX_RUNS];
   int               runs;
   int               iter_pos;

   logic [ROW_W-1:0] build_end [MAX_RUNS+2];
   logic             build_mark [MAX_RUNS+2];
   int               build_cnt;

   rsp_item_type     awaited_rsp [$];

   function automatic int run_of(input int row);
      for (int i = 0; i < runs; i++)
         if (int'(run_end[i]) >= row) return i;
      return runs - 1;
   endfunction

   task automatic append_run(input int last, input logic mk);
      if (build_cnt > 0 && build_mark[build_cnt-1] == mk) begin
         build_end[build_cnt-1] = last[ROW_W-1:0];
      end else if (build_cnt < MAX_RUNS + 2) begin
         build_end[build_cnt]  = last[ROW_W-1:0];
         build_mark[build_cnt] = mk;
         build_cnt++;
      end
   endtask

   task automatic paint_rows(input int a, input int b, input logic mk, output status_type st);
      int first_row;
      int last;
      build_cnt = 0;
      for (int i = 0; i < runs; i++) begin
         first_row = (i == 0) ? 0 : int'(run_end[i-1]) + 1;
         if (first_row < a) begin
            last = (int'(run_end[i]) > a - 1) ? a - 1 : int'(run_end[i]);
            append_run(last, run_mark[i]);
         end
      end
      append_run(b, mk);
      for (int i = 0; i < runs; i++)
         if (int'(run_end[i]) > b) append_run(int'(run_end[i]), run_mark[i]);
      if (build_cnt > MAX_RUNS) begin
         st = ST_FULL;
      end else begin
         for (int i = 0; i < build_cnt; i++) begin
            run_end[i]  = build_end[i];
            run_mark[i] = build_mark[i];
         end
         runs = build_cnt;
         st   = ST_OK;
      end
   endtask

   task automatic predict_rsp(input op_type op, input int a, input int b, input logic mk,
                              input logic up, output rsp_item_type r);
      int ia;
      int ib;
      int first;
      status_type st;
      first = 0;
      st    = ST_OK;
      r     = '0;
      case (op)
         OP_SET: begin
            if (a > LAST_ROW || b > LAST_ROW || a > b) st = ST_RANGE;
            else paint_rows(a, b, mk, st);
         end
         OP_GET: begin
            if (a > LAST_ROW) st = ST_RANGE;
            else r.flag = run_mark[run_of(a)];
         end
         OP_ALL: begin
            if (a > LAST_ROW || b > LAST_ROW) begin
               st = ST_RANGE;
            end else begin
               ia = run_of(a);
               ib = run_of(b);
               r.flag = run_mark[ia] && ia == ib;
            end
         end
         OP_NEXT: begin
            first = a;
            if (a > LAST_ROW) begin
               st = ST_RANGE;
            end else begin
               ia = run_of(a);
               if (!run_mark[ia]) begin
                  if (up) first = (ia > 0) ? int'(run_end[ia-1]) : -1;
                  else first = int'(run_end[ia]) + 1;
               end
            end
         end
         OP_END: begin
            if (a > LAST_ROW) begin
               st = ST_RANGE;
            end else begin
               ia = run_of(a);
               if (up) first = (ia > 0) ? int'(run_end[ia-1]) + 1 : 0;
               else first = int'(run_end[ia]);
            end
         end
         OP_ONE: begin
            if (runs == 1) begin
               if (run_mark[0]) begin
                  r.flag = 1'b1;
                  r.row_second = ROW_W'(LAST_ROW);
               end
            end else if (runs == 2) begin
               r.flag = 1'b1;
               if (run_mark[0]) begin
                  r.row_second = run_end[0];
               end else begin
                  first = int'(run_end[0]) + 1;
                  r.row_second = ROW_W'(LAST_ROW);
               end
            end else if (runs == 3 && run_mark[1]) begin
               r.flag = 1'b1;
               first = int'(run_end[0]) + 1;
               r.row_second = run_end[1];
            end
         end
         OP_ISTART: iter_pos = 0;
         default: begin
            while (iter_pos < runs && !run_mark[iter_pos]) iter_pos++;
            if (iter_pos < runs) begin
               r.flag = 1'b1;
               r.row_second = run_end[iter_pos];
               first = (iter_pos == 0) ? 0 : int'(run_end[iter_pos-1]) + 1;
               iter_pos++;
            end
         end
      endcase
      r.row_first  = first[WORK_W-1:0];
      r.any_marked = runs > 1 || run_mark[0];
      r.status     = st;
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         runs     = 1;
         run_end[0]  = ROW_W'(LAST_ROW);
         run_mark[0] = 1'b0;
         iter_pos = 0;
         fail_count = 0;
         full_seen  = 0;
         rsp_count  = 0;
         awaited_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got.flag       = rsp_tdata[0];
            got.row_first  = rsp_tdata[17:1];
            got.row_second = rsp_tdata[32:18];
            got.any_marked = rsp_tdata[33];
            got.status     = status_type'(rsp_tuser);
            if (awaited_rsp.size() == 0) begin
               $display("%0t: response beat with nothing expected", $realtime);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               if (got.flag != want.flag)
                  report_mismatch("flag", int'(got.flag), int'(want.flag));
               if (got.row_first != want.row_first)
                  report_mismatch("row_first", int'($signed(got.row_first)),
                                  int'($signed(want.row_first)));
               if (got.row_second != want.row_second)
                  report_mismatch("row_second", int'(got.row_second), int'(want.row_second));
               if (got.any_marked != want.any_marked)
                  report_mismatch("any_marked", int'(got.any_marked), int'(want.any_marked));
               if (got.status != want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
               if (rsp_tdata[39:34] != '0)
                  report_mismatch("pad bits", int'(rsp_tdata[39:34]), 0);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_rsp(op_type'(req_tuser), int'(req_tdata[14:0]), int'(req_tdata[29:15]),
                        req_tdata[30], req_tdata[31], want);
            if (want.status == ST_FULL) full_seen++;
            awaited_rsp.push_back(want);
         end
      end
      pending_count = awaited_rsp.size();
   end

endmodule

### sim/row_run_mark_table_test.sv
`timescale 1ns / 1ps
// Top of the row_run_mark_table testbench: clock, reset, request stimulus and verdict.
// Depends on rrmt_pkg, row_run_mark_table and rrmt_checker.
module row_run_mark_table_test;
   import rrmt_pkg::*;

   localparam int LAST_ROW   = DEF_LAST_ROW;
   localparam int CYCLE_CAP  = 3000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // row_a[14:0], row_b[29:15], mark_value[30], direction_up[31]
   logic [2:0]  req_tuser;    // op[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // flag[0], row_first[17:1], row_second[32:18], any_marked[33]
   logic [1:0]  rsp_tuser;    // status[1:0]

   int fail_count;
   int pending_count;
   int full_seen;
   int rsp_count;
   int tx_idle_pct;
   int rx_idle_pct;
   int cycle_count = 0;

   row_run_mark_table dut (.*);
   rrmt_checker watch (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else       rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // one request beat; afterwards the sender may drop valid and go quiet
   task automatic issue_op(input op_type op, input int a, input int b, input logic mk,
                           input logic up);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {up, mk, b[14:0], a[14:0]};
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain_rsp;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // rows mostly clustered in a narrow window so runs pile up; sometimes anywhere
   function automatic int pick_row(input int base);
      if ($urandom_range(99) < 25) return $urandom_range(LAST_ROW);
      return base + $urandom_range(200);
   endfunction

   task automatic random_op;
      int a;
      int b;
      int base;
      int tmp;
      int roll;
      op_type op;
      base = ($urandom_range(3) == 0) ? LAST_ROW - 200 : $urandom_range(600);
      a = pick_row(base);
      b = ($urandom_range(99) < 70) ? a + $urandom_range(12) : pick_row(base);
      if (b > LAST_ROW) b = LAST_ROW;
      roll = $urandom_range(99);
      if (roll < 38) op = OP_SET;
      else op = op_type'($urandom_range(1, 7));
      if (op == OP_SET && a > b && $urandom_range(99) < 80) begin
         tmp = a; a = b; b = tmp;
      end
      // now and then wipe the table so small-run cases come back
      if (op == OP_SET && $urandom_range(99) < 3) begin
         a = 0;
         b = LAST_ROW;
      end
      issue_op(op, a, b, 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (op == OP_ISTART || ($urandom_range(99) < 10))
         repeat ($urandom_range(1, 4)) issue_op(OP_INEXT, 0, 0, 1'b0, 1'b0);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = OP_GET;
      tx_idle_pct = 6;
      rx_idle_pct = 88;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, every op
      issue_op(OP_GET, 0, 0, 1'b0, 1'b0);
      issue_op(OP_GET, LAST_ROW, 0, 1'b0, 1'b0);
      issue_op(OP_ONE, 0, 0, 1'b0, 1'b0);
      issue_op(OP_NEXT, 100, 0, 1'b0, 1'b1);
      issue_op(OP_NEXT, 100, 0, 1'b0, 1'b0);
      issue_op(OP_INEXT, 0, 0, 1'b0, 1'b0);
      issue_op(OP_SET, 0, LAST_ROW, 1'b1, 1'b0);
      issue_op(OP_ALL, LAST_ROW, 0, 1'b0, 1'b0);     // reversed, same marked run
      issue_op(OP_ONE, 0, 0, 1'b0, 1'b0);
      issue_op(OP_SET, 500, 400, 1'b1, 1'b1);        // reversed set range
      issue_op(OP_SET, 0, 0, 1'b0, 1'b0);
      issue_op(OP_SET, LAST_ROW, LAST_ROW, 1'b0, 1'b0);
      issue_op(OP_ONE, 0, 0, 1'b0, 1'b0);
      issue_op(OP_END, 0, 0, 1'b0, 1'b1);            // mark end on an unmarked row
      issue_op(OP_END, 5, 0, 1'b0, 1'b1);
      issue_op(OP_END, 5, 0, 1'b0, 1'b0);
      issue_op(OP_NEXT, 0, 0, 1'b0, 1'b1);
      issue_op(OP_NEXT, LAST_ROW, 0, 1'b0, 1'b0);
      issue_op(OP_ALL, 1, LAST_ROW - 1, 1'b0, 1'b0);
      issue_op(OP_ISTART, 0, 0, 1'b0, 1'b0);
      issue_op(OP_INEXT, 0, 0, 1'b0, 1'b0);
      issue_op(OP_INEXT, 0, 0, 1'b0, 1'b0);
      issue_op(OP_SET, 0, LAST_ROW, 1'b0, 1'b1);
      // isolated marked rows until the run list overflows
      for (int i = 1; i <= 34; i++) issue_op(OP_SET, 2 * i, 2 * i, 1'b1, 1'b0);
      issue_op(OP_ISTART, 0, 0, 1'b0, 1'b0);
      drain_rsp();

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 88 : 0;
         rx_idle_pct = (phase == 1) ? 6 : (phase == 0) ? 88 : 0;
         for (int n = 0; n < 170; n++) begin
            random_op();
            if (n == 85) drain_rsp();
         end
      end

      drain_rsp();
      repeat (600) @(posedge clock);
      $display("covered %0d responses, %0d table-full rejections,", rsp_count, full_seen);
      $display("all eight operations under three sender/receiver stall mixes");
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
